// File: rtl/core/mrsr_pkg.sv
// ----------------------------------------------------------------------------
// mrsr_pkg
// Shared types and constants of the multi-reader sample ring: field widths,
// command, status and mode codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package mrsr_pkg;

  // Field widths of the request and result items
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BLEN_W     = 10;
  localparam int unsigned PORT_W     = 2;
  localparam int unsigned WANT_W     = 7;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned COUNT_W    = 32;

  // Stream packing
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ACT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PORTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_TO_PLAY = 2'd2;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PLAY   = 2'd1,
    MODE_SILENT = 2'd2,
    MODE_HIDDEN = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSH_STORED  = 3'd0,
    ST_PUSH_DROPPED = 3'd1,
    ST_PULL_DATA    = 3'd2,
    ST_PULL_NONE    = 3'd3,
    ST_BAD_PORT     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_PULL
  } state_e;

endpackage

// File: rtl/core/multi_reader_sample_ring.sv
// ----------------------------------------------------------------------------
// multi_reader_sample_ring
// Ring of 16-bit audio samples with one write pointer and one read pointer
// per output port. Pushes are admitted burst-wise against the free space of
// the slowest active port; pulls stream samples out of the ring memory.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      content
//  --------  ---------  -----------------------------  -----------------------
//  s_axis    in         s_axis_tvalid / s_axis_tready  push sample / pull req
//  m_axis    out        m_axis_tvalid / m_axis_tready  one result per beat
//  cfg       in         cfg_valid_i / cfg_ready_o      register index + data
//
//  A request is taken in S_IDLE and decided in S_EVAL. A pull that
//  delivers N samples then streams them at one per cycle from the ring
//  memory (one registered read port) while the output is not stalled.
//  A stalled result stays in the output register; a new request is still
//  accepted and waits in S_EVAL or S_PULL until that register frees up.
//  Reset clears pointers, counters and control registers at once. The ring
//  memory needs no clearing pass: a read only reaches entries behind the
//  write pointer, which have all been written.
// ----------------------------------------------------------------------------
module multi_reader_sample_ring
  import mrsr_pkg::*;
#(
  parameter int unsigned CAPACITY = 1023,
  parameter int unsigned PULL_MAX = 64,
  parameter int unsigned NPORTS   = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] sample_in, [25:16] burst_length, [27:26] port,
  // [34:28] frames_wanted, [39:35] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] command, [1] burst_first
  input  logic [IN_USER_W-1:0]  s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] sample_out, [22:16] pulled_count, [23] finished
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] sample_valid, [3:1] result_status
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  output logic                  m_axis_tlast,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned RING = CAPACITY + 1;
  localparam int unsigned AW   = $clog2(RING);
  localparam int unsigned PIW  = (NPORTS > 1) ? $clog2(NPORTS) : 1;
  localparam int unsigned NP2  = 1 << $clog2(NPORTS);
  localparam int unsigned NAW  = $clog2(NPORTS + 1);
  localparam int unsigned XW   = (NAW > ACT_W) ? NAW : ACT_W;
  localparam int unsigned CW   = (AW > BLEN_W) ? AW : BLEN_W;
  localparam int unsigned QW   = (AW > WANT_W) ? AW : WANT_W;

  // Ring distance from a read pointer to the write pointer
  function automatic logic [AW-1:0] ring_fill(input logic [AW-1:0] wp,
                                              input logic [AW-1:0] rp);
    logic [AW:0] diff;
    if (wp >= rp) begin
      diff = {1'b0, wp} - {1'b0, rp};
    end else begin
      diff = (AW+1)'(RING) - {1'b0, rp} + {1'b0, wp};
    end
    return diff[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY)) ? '0 : p + AW'(1);
  endfunction

  // Configuration registers
  logic [MODE_W-1:0]     mode_q;
  logic [ACT_W-1:0]      active_q;
  logic [COUNT_W-1:0]    ftp_q;

  // Ring state
  logic signed [SAMPLE_W-1:0] mem [RING];
  logic [AW-1:0]         wptr_q;
  logic [AW-1:0]         rptr_q [NPORTS];
  logic [COUNT_W-1:0]    cnt_q  [NPORTS];
  logic                  burst_acc_q, burst_acc_d;

  // Request held for evaluation
  state_e                state_q, state_d;
  logic                  cmd_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                  first_q;
  logic [BLEN_W-1:0]     blen_q;
  logic [PORT_W-1:0]     port_q;
  logic [WANT_W-1:0]     fwant_q;
  logic [AW-1:0]         fill_q [NPORTS];

  // Pull sequencing
  logic [WANT_W-1:0]     want_q, want_d;
  logic [WANT_W-1:0]     remain_q, remain_d;
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic                  rd_pend_q, rd_pend_d;
  logic                  rd_last_q;

  // Output register
  logic                  out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic                  out_svalid_q, out_svalid_d;
  logic                  out_last_q, out_last_d;
  status_e               out_status_q, out_status_d;
  logic [WANT_W-1:0]     out_count_q, out_count_d;
  logic                  out_fin_q, out_fin_d;
  logic                  out_load;
  logic                  out_free;

  logic                  in_take;
  logic [XW-1:0]         n_act;
  logic [PIW-1:0]        port_idx;
  logic [AW-1:0]         node [2*NP2-1];
  logic [AW-1:0]         max_fill;
  logic [AW-1:0]         room;
  logic                  fin_w;
  logic                  push_ok;
  logic                  bad_port;
  logic [WANT_W-1:0]     want_clip;
  logic [WANT_W-1:0]     grant;
  logic                  mem_we;
  logic                  wptr_adv;
  logic                  cnt_add;
  logic                  rd_issue;
  logic                  move;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign port_idx      = PIW'(port_q);

  // Clamp the active port count to the number of ports built
  assign n_act = (XW'(active_q) > XW'(NPORTS)) ? XW'(NPORTS) : XW'(active_q);

  // Largest fill over the active ports: tree over the registered fills
  always_comb begin
    for (int i = 0; i < 2*NP2-1; i++) begin
      node[i] = '0;
    end
    for (int i = 0; i < NPORTS; i++) begin
      if (XW'(i) < n_act) begin
        node[NP2-1+i] = fill_q[i];
      end
    end
    for (int k = NP2-2; k >= 0; k--) begin
      node[k] = (node[2*k+1] > node[2*k+2]) ? node[2*k+1] : node[2*k+2];
    end
  end

  assign max_fill = node[0];
  assign room     = AW'(CAPACITY) - max_fill;

  // Any active port at or past the frame target
  always_comb begin
    fin_w = 1'b0;
    for (int i = 0; i < NPORTS; i++) begin
      if (XW'(i) < n_act && cnt_q[i] >= ftp_q) begin
        fin_w = 1'b1;
      end
    end
  end

  // Push admission
  always_comb begin
    if (first_q) begin
      burst_acc_d = (blen_q != '0) && (room != '0) && (CW'(blen_q) <= CW'(room));
      push_ok     = burst_acc_d;
    end else begin
      burst_acc_d = burst_acc_q;
      push_ok     = burst_acc_q && (room != '0);
    end
  end

  // Pull grant: zero in idle mode, else clip to the limit, then to the port's fill
  assign bad_port  = XW'(port_q) >= n_act;
  assign want_clip = (fwant_q > WANT_W'(PULL_MAX)) ? WANT_W'(PULL_MAX) : fwant_q;

  always_comb begin
    if (mode_q == MODE_IDLE) begin
      grant = '0;
    end else if (QW'(want_clip) > QW'(fill_q[port_idx])) begin
      grant = WANT_W'(fill_q[port_idx]);
    end else begin
      grant = want_clip;
    end
  end

  // Next state and control
  always_comb begin
    state_d      = state_q;
    want_d       = want_q;
    remain_d     = remain_q;
    rd_pend_d    = rd_pend_q;
    mem_we       = 1'b0;
    wptr_adv     = 1'b0;
    cnt_add      = 1'b0;
    rd_issue     = 1'b0;
    move         = 1'b0;
    out_load     = 1'b0;
    out_sample_d = '0;
    out_svalid_d = 1'b0;
    out_last_d   = 1'b1;
    out_status_d = ST_PULL_NONE;
    out_count_d  = '0;
    out_fin_d    = fin_w;

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        if (cmd_q == CMD_PUSH) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_status_d = push_ok ? ST_PUSH_STORED : ST_PUSH_DROPPED;
            mem_we       = push_ok;
            wptr_adv     = push_ok;
            state_d      = S_IDLE;
          end
        end else if (bad_port || grant == '0) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_status_d = bad_port ? ST_BAD_PORT : ST_PULL_NONE;
            state_d      = S_IDLE;
          end
        end else begin
          // Book the frames now; samples follow from the ring
          cnt_add  = 1'b1;
          want_d   = grant;
          remain_d = grant;
          state_d  = S_PULL;
        end
      end

      S_PULL: begin
        move     = rd_pend_q && out_free;
        rd_issue = (remain_q != '0) && (!rd_pend_q || move);
        if (rd_issue) begin
          remain_d = remain_q - WANT_W'(1);
        end
        rd_pend_d = rd_issue || (rd_pend_q && !move);
        if (move) begin
          out_load     = 1'b1;
          out_sample_d = mode_q[1] ? '0 : rd_data_q;
          out_svalid_d = 1'b1;
          out_last_d   = rd_last_q;
          out_status_d = ST_PULL_DATA;
          out_count_d  = rd_last_q ? want_q : '0;
        end
        if (remain_q == '0 && !rd_pend_q) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Controller and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wptr_q      <= '0;
      burst_acc_q <= 1'b0;
      remain_q    <= '0;
      want_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NPORTS; i++) begin
        rptr_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      remain_q  <= remain_d;
      want_q    <= want_d;
      rd_pend_q <= rd_pend_d;
      if (state_q == S_EVAL && cmd_q == CMD_PUSH && out_free) begin
        burst_acc_q <= burst_acc_d;
      end
      if (wptr_adv) begin
        wptr_q <= ring_inc(wptr_q);
      end
      if (cnt_add) begin
        cnt_q[port_idx] <= cnt_q[port_idx] + COUNT_W'(grant);
      end
      if (rd_issue) begin
        rptr_q[port_idx] <= ring_inc(rptr_q[port_idx]);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      active_q <= ACT_W'(1);
      ftp_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PLAY_MODE:      mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_ACTIVE_PORTS:   active_q <= cfg_data_i[ACT_W-1:0];
        CFG_FRAMES_TO_PLAY: ftp_q    <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request and the per-port fills it is judged against
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= s_axis_tuser[0];
      first_q  <= s_axis_tuser[1];
      sample_q <= s_axis_tdata[15:0];
      blen_q   <= s_axis_tdata[25:16];
      port_q   <= s_axis_tdata[27:26];
      fwant_q  <= s_axis_tdata[34:28];
      for (int i = 0; i < NPORTS; i++) begin
        fill_q[i] <= ring_fill(wptr_q, rptr_q[i]);
      end
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wptr_q] <= sample_q;
    end
    if (rd_issue) begin
      rd_data_q <= mem[rptr_q[port_idx]];
      rd_last_q <= (remain_q == WANT_W'(1));
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= out_sample_d;
      out_svalid_q <= out_svalid_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
      out_fin_q    <= out_fin_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_fin_q, out_count_q, out_sample_q};
  assign m_axis_tuser  = {out_status_q, out_svalid_q};
  assign m_axis_tlast  = out_last_q;

  // A fetched sample waits until the output register takes it
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_pend_q && !move) |=> rd_pend_q)
    else $error("pending ring read dropped");

  // Only the final sample of a pull carries a count, and it is nonzero
  a_pull_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast == (out_count_q != '0)))
    else $error("pulled count on the wrong sample");

  // No active port ever runs more than the capacity behind the writer
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (max_fill <= AW'(CAPACITY)))
    else $error("port fill beyond capacity");

  // A pull only runs while no memory write is issued
  a_no_write_in_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PULL) |-> (!mem_we && !s_axis_tready))
    else $error("ring written during pull");

endmodule

// File: verif/ring_shadow_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_shadow_pkg
// Testbench-side copy of the sample ring. It tracks the write and read
// pointers, burst admission, frame counts and registers, and holds the
// result beats due for every accepted request so that each beat leaving the
// block is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
package ring_shadow_pkg;
  import mrsr_pkg::*;

  localparam int unsigned RING_CAP   = 1023;
  localparam int unsigned RING_SLOTS = RING_CAP + 1;
  localparam int unsigned PTR_W      = $clog2(RING_SLOTS);
  localparam int unsigned PULL_LIMIT = 64;
  localparam int unsigned PORT_CNT   = 4;

  // One request as it travels on the input stream
  typedef struct {
    cmd_e                cmd;
    logic [SAMPLE_W-1:0] sample;
    logic                first;
    logic [BLEN_W-1:0]   blen;
    logic [PORT_W-1:0]   port;
    logic [WANT_W-1:0]   want;
  } ring_req_t;

  // One result beat
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                valid;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [WANT_W-1:0]   count;
    logic                fin;
  } ring_beat_t;

  class ring_shadow;
    logic [SAMPLE_W-1:0] store_mem [RING_SLOTS];
    logic [PTR_W-1:0]    wr_ptr;
    logic [PTR_W-1:0]    rd_ptr [PORT_CNT];
    logic [31:0]         frames_pulled [PORT_CNT];
    logic                burst_ok;
    mode_e               mode;
    logic [ACT_W-1:0]    active_cfg;
    logic [31:0]         frame_target;
    ring_beat_t          beats_due [$];
    int unsigned         error_cnt;

    function new();
      foreach (store_mem[i]) store_mem[i] = '0;
      foreach (rd_ptr[i]) begin
        rd_ptr[i]        = '0;
        frames_pulled[i] = '0;
      end
      wr_ptr       = '0;
      burst_ok     = 1'b0;
      mode         = MODE_IDLE;
      active_cfg   = ACT_W'(1);
      frame_target = '0;
      error_cnt    = 0;
    endfunction

    // Ports taking part, clipped to the number that exists
    function int unsigned ports_live();
      return (active_cfg > PORT_CNT) ? PORT_CNT : active_cfg;
    endfunction

    // Distance from a read pointer to the write pointer, modulo the ring
    function int unsigned port_fill(int unsigned p);
      logic [PTR_W-1:0] gap;
      gap = wr_ptr - rd_ptr[p];
      return gap;
    endfunction

    // Free space as seen by the slowest active port
    function int unsigned room();
      int unsigned best;
      best = RING_CAP;
      for (int unsigned i = 0; i < ports_live(); i++)
        if (RING_CAP - port_fill(i) < best) best = RING_CAP - port_fill(i);
      return best;
    endfunction

    function logic finished_now();
      for (int unsigned i = 0; i < ports_live(); i++)
        if (frames_pulled[i] >= frame_target) return 1'b1;
      return 1'b0;
    endfunction

    function int unsigned beats_left();
      return beats_due.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PLAY_MODE:      mode = mode_e'(value[MODE_W-1:0]);
        CFG_ACTIVE_PORTS:   active_cfg = value[ACT_W-1:0];
        CFG_FRAMES_TO_PLAY: frame_target = value;
        default: ;
      endcase
    endfunction

    // Lone beat that closes a push or an empty or refused pull
    function ring_beat_t lone_beat(logic [STATUS_W-1:0] status);
      ring_beat_t b;
      b.sample = '0;
      b.valid  = 1'b0;
      b.last   = 1'b1;
      b.status = status;
      b.count  = '0;
      b.fin    = finished_now();
      return b;
    endfunction

    // Append one due beat behind the ones already queued
    function void queue_beat(ring_beat_t b);
      beats_due.insert(beats_due.size(), b);
    endfunction

    // Apply an accepted request and queue the beats it must produce
    function void note_request(ring_req_t rq);
      ring_beat_t  b;
      int unsigned space;
      int unsigned take;
      logic        keep;
      logic        fin;
      if (rq.cmd == CMD_PUSH) begin
        // Admit a burst once, at its first sample
        space = room();
        if (rq.first) begin
          burst_ok = (rq.blen != 0) && (space != 0) && (rq.blen <= space);
          keep     = burst_ok;
        end else begin
          keep = burst_ok && (space != 0);
        end
        if (keep) begin
          store_mem[wr_ptr] = rq.sample;
          wr_ptr++;
        end
        queue_beat(lone_beat(keep ? ST_PUSH_STORED : ST_PUSH_DROPPED));
      end else if (rq.port >= ports_live()) begin
        queue_beat(lone_beat(ST_BAD_PORT));
      end else begin
        // Clip the request to the pull limit and to what the port holds
        take = (rq.want > PULL_LIMIT) ? PULL_LIMIT : rq.want;
        if (mode == MODE_IDLE) take = 0;
        else if (take > port_fill(rq.port)) take = port_fill(rq.port);
        if (take == 0) begin
          queue_beat(lone_beat(ST_PULL_NONE));
        end else begin
          frames_pulled[rq.port] += take;
          fin = finished_now();
          for (int unsigned k = 0; k < take; k++) begin
            b.sample = (mode == MODE_SILENT || mode == MODE_HIDDEN) ?
                       '0 : store_mem[rd_ptr[rq.port]];
            rd_ptr[rq.port]++;
            b.valid  = 1'b1;
            b.last   = (k + 1 == take);
            b.status = ST_PULL_DATA;
            b.count  = b.last ? WANT_W'(take) : '0;
            b.fin    = fin;
            queue_beat(b);
          end
        end
      end
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        error_cnt++;
        $error("%s: expected %0h, got %0h", label, want, got);
      end
    endfunction

    // Compare one accepted result beat with the oldest one due
    function void check_beat(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user,
                             logic tail);
      ring_beat_t due;
      if (beats_due.size() == 0) begin
        error_cnt++;
        $error("result beat with nothing outstanding: data %h user %h", data, user);
        return;
      end
      due = beats_due.pop_front();
      compare_field("sample_out", due.sample, data[SAMPLE_W-1:0]);
      compare_field("pulled_count", due.count, data[SAMPLE_W +: WANT_W]);
      compare_field("finished", due.fin, data[SAMPLE_W + WANT_W]);
      compare_field("result_status", due.status, user[1 +: STATUS_W]);
      compare_field("sample_valid", due.valid, user[0]);
      compare_field("last", due.last, tail);
    endfunction
  endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the multi-reader sample ring. A short directed run
// covers modes, port limits, burst admission and request clipping; a short
// run lets one port fall behind another; random mixes of bursts and pulls
// follow under several register settings with random back-pressure on both
// streams but in the last mix. Every result beat is checked against the ring copy.
// ----------------------------------------------------------------------------
module tb_top;
  import mrsr_pkg::*;
  import ring_shadow_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned RUN_LIMIT_NS = 20_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ring_shadow  shadow;
  bit          bursty   = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned items_sent = 0;

  multi_reader_sample_ring #(
    .CAPACITY(RING_CAP),
    .PULL_MAX(PULL_LIMIT),
    .NPORTS  (PORT_CNT)
  ) u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Check every beat taken from the result stream
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      shadow.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Result-side back-pressure: short random stalls, or one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && bursty && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one request, hold it until taken, then record it
  task automatic send_request(input ring_req_t rq);
    cfg_valid_i <= 1'b0;
    if (bursty && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({rq.want, rq.port, rq.blen, rq.sample});
    s_axis_tuser  <= {rq.first, rq.cmd};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    shadow.note_request(rq);
    items_sent++;
  endtask

  // Push one sample; the pull fields carry noise
  task automatic push_sample(input logic [SAMPLE_W-1:0] sample, input logic first,
                             input logic [BLEN_W-1:0] blen);
    ring_req_t rq;
    rq.cmd    = CMD_PUSH;
    rq.sample = sample;
    rq.first  = first;
    rq.blen   = blen;
    rq.port   = PORT_W'($urandom_range(0, 3));
    rq.want   = WANT_W'($urandom_range(0, 127));
    send_request(rq);
  endtask

  // Pull request; the push fields carry noise
  task automatic pull_from(input logic [PORT_W-1:0] port, input logic [WANT_W-1:0] want);
    ring_req_t rq;
    rq.cmd    = CMD_PULL;
    rq.sample = SAMPLE_W'($urandom);
    rq.first  = 1'($urandom_range(0, 1));
    rq.blen   = BLEN_W'($urandom_range(0, 1023));
    rq.port   = port;
    rq.want   = want;
    send_request(rq);
  endtask

  // Burst with a declared length and a possibly different sample count
  task automatic push_burst(input logic [BLEN_W-1:0] declared, input int unsigned count);
    for (int unsigned n = 0; n < count; n++) push_sample(SAMPLE_W'($urandom), n == 0, declared);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    shadow.write_reg(idx, value);
  endtask

  // Withdraw requests and wait for every due beat, then let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    while (shadow.beats_left() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(input mode_e mode, input logic [ACT_W-1:0] ports,
                          input logic [31:0] target);
    write_reg(CFG_PLAY_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_ACTIVE_PORTS, CFG_DATA_W'(ports));
    write_reg(CFG_FRAMES_TO_PLAY, target);
  endtask

  // Random mix: mostly well-formed bursts and pulls, some malformed bursts
  task automatic run_mix(input int unsigned n_items, input int unsigned max_len);
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        len = $urandom_range(1, max_len);
        push_burst(BLEN_W'(len), len);
      end else if (pick == 5) begin
        case ($urandom_range(0, 3))
          0: push_burst(BLEN_W'($urandom_range(512, 1023)), $urandom_range(1, 4));
          1: push_burst('0, $urandom_range(1, 3));
          2: repeat ($urandom_range(1, 3))
               push_sample(SAMPLE_W'($urandom), 1'b0, BLEN_W'($urandom));
          default: begin
            len = $urandom_range(1, max_len);
            push_burst(BLEN_W'(len), len + $urandom_range(1, 3));
          end
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0:       len = 0;
          1:       len = $urandom_range(PULL_LIMIT + 1, 127);
          default: len = $urandom_range(1, PULL_LIMIT);
        endcase
        pull_from(PORT_W'($urandom_range(0, PORT_CNT - 1)), WANT_W'(len));
      end
    end
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned extra;
    shadow = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: idle mode, one port, frame target zero
    pull_from(2'd0, 7'd5);
    pull_from(2'd1, 7'd1);
    push_sample(16'h1111, 1'b1, 10'd0);
    push_sample(16'h2222, 1'b0, 10'd9);
    push_sample(16'h7FFF, 1'b1, 10'd3);
    push_sample(16'h8000, 1'b0, 10'd3);
    push_sample(16'hFFFF, 1'b0, 10'd3);
    push_sample(16'h0000, 1'b0, 10'd3);
    push_sample(16'h5A5A, 1'b1, 10'd1023);
    push_sample(16'hA5A5, 1'b1, 10'd512);
    settle();

    // Play with an oversized port count and the highest frame target
    set_regs(MODE_PLAY, 3'd7, 32'hFFFF_FFFF);
    pull_from(2'd0, 7'd127);
    pull_from(2'd3, 7'd0);
    pull_from(2'd3, 7'd64);
    pull_from(2'd2, 7'd2);
    settle();

    // No active ports: full room, every pull refused
    set_regs(MODE_SILENT, 3'd0, 32'd4);
    pull_from(2'd0, 7'd10);
    push_sample(16'h0F0F, 1'b1, 10'd1023);
    push_sample(16'hF0F0, 1'b0, 10'd1023);
    settle();

    set_regs(MODE_HIDDEN, 3'd3, 32'd6);
    pull_from(2'd2, 7'd64);
    pull_from(2'd3, 7'd64);
    settle();

    // Port 1 is left behind while port 0 keeps draining
    set_regs(MODE_PLAY, 3'd2, 32'd0);
    for (int n = 0; n < 3; n++) begin
      len   = $urandom_range(1, 12);
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      push_burst(BLEN_W'(len), len + extra);
      if ($urandom_range(0, 2) == 0) pull_from(2'd0, 7'd64);
    end
    push_sample(SAMPLE_W'($urandom), 1'b1, 10'd1);
    push_sample(SAMPLE_W'($urandom), 1'b0, 10'd1);
    pull_from(2'd1, 7'd127);
    push_burst(10'd8, 9);
    settle();

    // Random mixes; the first one starts behind a long result-side hold
    set_regs(MODE_PLAY, 3'd4, $urandom_range(0, 300));
    hold_req = 1'b1;
    run_mix(45, 16);
    settle();

    set_regs(MODE_SILENT, 3'd2, 32'd0);
    run_mix(25, 24);
    settle();
    run_mix(20, 24);
    settle();

    set_regs(MODE_HIDDEN, 3'd5, $urandom_range(0, 400));
    run_mix(40, 12);
    settle();

    set_regs(MODE_IDLE, 3'd1, 32'hFFFF_FFFF);
    run_mix(25, 8);
    settle();

    // Last stretch at full rate on both sides
    bursty = 1'b0;
    set_regs(MODE_PLAY, 3'd3, $urandom);
    run_mix(50, 16);
    settle();

    if (shadow.error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
